// ----- hw/rtl/url_percent_decoder_macros.svh -----
// Assertion macros shared by the percent decoder modules.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UPD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UPD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hw/rtl/upd_pkg.sv -----
// Shared types, constants and helper functions for the percent decoder.
package upd_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [2:0] {
		PH_TEXT = 3'b001,
		PH_PCT  = 3'b010,
		PH_HI   = 3'b100
	} upd_phase_t;

	// One queued input item: up to two results.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       has_data;
		logic       last;
	} upd_entry_t;

	typedef struct packed {
		logic       nonempty;
		upd_entry_t head;
	} upd_qstat_t;

	function automatic logic [7:0] text_byte(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] l;
		l = c;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			return c - CH_ZERO;
		end
		if (c inside {[CH_UA:CH_UZ]}) begin
			l = c + CASE_OFS;
		end
		return l - CH_LA + HEX_TEN;
	endfunction

endpackage

// ----- hw/rtl/upd_front.sv -----
// Front end: accepts input bytes, tracks escape state and classifies results.
`include "url_percent_decoder_macros.svh"
module upd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                in_stall,
	input  logic                q_full,
	output logic                push,
	output upd_pkg::upd_entry_t push_entry
);

	upd_pkg::upd_phase_t phase_q;
	upd_pkg::upd_phase_t nph;
	logic [7:0]          first_q;
	logic [7:0]          nf;
	logic [7:0]          b0;
	logic [7:0]          b1;
	logic [1:0]          cnt;
	logic                has_data;
	logic                accept;
	logic [7:0]          hv_hi;
	logic [7:0]          hv_lo;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign hv_hi = upd_pkg::hex_val(first_q);
	assign hv_lo = upd_pkg::hex_val(in_byte);

	always_comb begin
		cnt      = 2'd0;
		b0       = upd_pkg::CH_NUL;
		b1       = upd_pkg::CH_NUL;
		nph      = phase_q;
		nf       = first_q;
		has_data = 1'b1;
		case (phase_q)
			upd_pkg::PH_PCT: begin
				if (in_byte == upd_pkg::CH_NUL) begin
					cnt = 2'd1;
					nph = upd_pkg::PH_TEXT;
				end else begin
					nf  = in_byte;
					nph = upd_pkg::PH_HI;
				end
			end
			upd_pkg::PH_HI: begin
				if (in_byte == upd_pkg::CH_NUL) begin
					// drop the '%', flush the pending follower unless it is a '%', then pass the zero
					if (first_q != upd_pkg::CH_PCT) begin
						b0  = upd_pkg::text_byte(first_q);
						cnt = 2'd2;
					end else begin
						cnt = 2'd1;
					end
				end else begin
					// the low value is OR-ed in whole, not just its nibble
					b0  = {hv_hi[3:0], 4'h0} | hv_lo;
					cnt = 2'd1;
				end
				nph = upd_pkg::PH_TEXT;
				nf  = upd_pkg::CH_NUL;
			end
			default: begin
				if (in_byte == upd_pkg::CH_PCT) begin
					nph = upd_pkg::PH_PCT;
				end else begin
					b0  = upd_pkg::text_byte(in_byte);
					cnt = 2'd1;
				end
			end
		endcase
		if (in_last) begin
			if (nph == upd_pkg::PH_HI && nf != upd_pkg::CH_PCT) begin
				if (cnt == 2'd0) begin
					b0 = upd_pkg::text_byte(nf);
				end else begin
					b1 = upd_pkg::text_byte(nf);
				end
				cnt = cnt + 2'd1;
			end
			nph = upd_pkg::PH_TEXT;
			nf  = upd_pkg::CH_NUL;
			// the string end always yields a result, empty if need be
			if (cnt == 2'd0) begin
				cnt      = 2'd1;
				has_data = 1'b0;
			end
		end
	end

	assign push                = accept && (cnt != 2'd0);
	assign push_entry.cnt      = cnt;
	assign push_entry.b0       = b0;
	assign push_entry.b1       = b1;
	assign push_entry.has_data = has_data;
	assign push_entry.last     = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_TEXT;
			first_q <= upd_pkg::CH_NUL;
		end else if (accept) begin
			phase_q <= nph;
			first_q <= nf;
		end
	end

	`UPD_ASSERT_IMPL(a_empty_only_at_end, push && !has_data, in_last && (cnt == 2'd1),
		"empty result pushed away from string end")
	`UPD_ASSERT_NEXT(a_last_resets_phase, accept && in_last, phase_q == upd_pkg::PH_TEXT,
		"escape state not cleared after string end")
	`UPD_ASSERT_IMPL(a_pair_limit, push, cnt != 2'd3, "more than two results for one item")

endmodule

// ----- hw/rtl/upd_fifo.sv -----
// Short queue of classified items between the front and back ends.
`include "url_percent_decoder_macros.svh"
module upd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upd_pkg::upd_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output upd_pkg::upd_qstat_t qstat
);

	localparam logic [upd_pkg::QAW:0] DEPTH_C = (upd_pkg::QAW + 1)'(upd_pkg::QDEPTH);

	upd_pkg::upd_entry_t        mem_q [upd_pkg::QDEPTH];
	logic [upd_pkg::QAW-1:0]    wr_ptr_q;
	logic [upd_pkg::QAW-1:0]    rd_ptr_q;
	logic [upd_pkg::QAW:0]      cnt_q;

	assign full           = (cnt_q == DEPTH_C);
	assign qstat.nonempty = (cnt_q != '0);
	assign qstat.head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`UPD_ASSERT_IMPL(a_no_push_full, push, !full, "transfer into a full queue")
	`UPD_ASSERT_IMPL(a_no_pop_empty, pop, qstat.nonempty, "pop from an empty queue")
	`UPD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= DEPTH_C, "queue fill beyond depth")

endmodule

// ----- hw/rtl/upd_back.sv -----
// Back end: expands queued items into results behind an output register.
`include "url_percent_decoder_macros.svh"
module upd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  upd_pkg::upd_qstat_t qstat,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                run_last,
	output logic                string_end
);

	logic       res_valid_q;
	logic [7:0] out_byte_q;
	logic       out_valid_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       idx_q;
	logic       load;
	logic       emit;
	logic       last_res;

	assign load     = !res_valid_q || !res_stall;
	assign emit     = load && qstat.nonempty;
	assign last_res = (qstat.head.cnt == 2'd1) || idx_q;
	assign pop      = emit && last_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= qstat.nonempty;
			end
			if (emit) begin
				idx_q <= !last_res;
			end
		end
	end

	// hold the payload while stalled
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= idx_q ? qstat.head.b1 : qstat.head.b0;
			out_valid_q  <= qstat.head.has_data;
			run_last_q   <= last_res;
			string_end_q <= last_res && qstat.head.last;
		end
	end

	assign res_valid  = res_valid_q;
	assign out_byte   = out_byte_q;
	assign out_valid  = out_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

	`UPD_ASSERT_NEXT(a_second_follows, emit && !last_res, idx_q, "second result of an item lost")
	`UPD_ASSERT_IMPL(a_idx_pair, idx_q, qstat.nonempty && (qstat.head.cnt == 2'd2),
		"result index set without a pair pending")
	`UPD_ASSERT_NEXT(a_hold_stalled, res_valid_q && res_stall,
		res_valid_q && $stable(out_byte_q), "stalled result changed")

endmodule

// ----- hw/rtl/url_percent_decoder.sv -----
// Top level of the form-style percent decoder.
// Decodes a byte string one byte per transfer: '+' gives a space, '%' and two
// nonzero followers give one byte, and a broken escape is dropped with its
// followers passed as text, but a '%' follower is dropped too. An input byte
// is taken every cycle while the four-entry item queue has room; each input
// byte gives zero, one or two results, and the output register sends one
// result per cycle while res_stall is low, so an item with two results holds
// the output for both in turn and the queue soaks up the gap. A result passes
// from its input transfer through a queue entry and then the output register
// before it is presented. The last byte of a string always yields at least
// one result, with string_end set on the final one.
module url_percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       run_last,
	output logic       string_end
);

	upd_pkg::upd_entry_t push_entry;
	upd_pkg::upd_qstat_t qstat;
	logic                push;
	logic                pop;
	logic                q_full;

	upd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	upd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.qstat      (qstat)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule
